// ===== rtl/fmvp_pkg.sv =====
// Package for the FM voice parameter packer.
// Holds the item, held-state and packed-result types and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package fmvp_pkg;

  localparam int VoiceSlots  = 32;
  localparam int SlotW       = 5;
  localparam int PosW        = 8;
  localparam int ByteW       = 8;
  localparam int OffW        = 7;
  localparam int AddrW       = 13;
  localparam int OpEnW       = 6;
  localparam int InDataW     = 24;
  localparam int OutDataW    = 24;

  localparam logic [PosW-1:0] PosOpEnd     = 8'd126;
  localparam logic [PosW-1:0] PosGlobalEnd = 8'd134;
  localparam logic [PosW-1:0] PosFeedback  = 8'd135;
  localparam logic [PosW-1:0] PosOscSync   = 8'd136;
  localparam logic [PosW-1:0] PosGlobal2   = 8'd140;
  localparam logic [PosW-1:0] PosLfoSync   = 8'd141;
  localparam logic [PosW-1:0] PosLfoWave   = 8'd142;
  localparam logic [PosW-1:0] PosLfoPacked = 8'd143;
  localparam logic [PosW-1:0] PosTranspose = 8'd144;
  localparam logic [PosW-1:0] PosNameFirst = 8'd145;
  localparam logic [PosW-1:0] PosLast      = 8'd154;

  localparam logic [ByteW-1:0] CharSpace   = 8'h20;
  localparam logic [AddrW-1:0] AddrBase    = 13'd6;

  typedef struct packed {
    logic [SlotW-1:0] voice_slot;
    logic [PosW-1:0]  unpacked_position;
    logic [ByteW-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [1:0] left_curve;
    logic [2:0] rate_scaling;
    logic [1:0] amp_mod_sens;
    logic       osc_mode;
    logic [2:0] feedback;
    logic       lfo_sync;
    logic [2:0] lfo_wave;
    logic       name_ended;
  } held_t;

  typedef struct packed {
    logic             emit;
    logic [OffW-1:0]  offset;
    logic [ByteW-1:0] value;
  } packed_res_t;

endpackage

// ===== rtl/fmvp_pack.sv =====
// Combinational packing of one unpacked voice byte.
// Maps a position to its packed offset and byte and updates the held fields.
// Depends on fmvp_pkg.
`timescale 1ns / 1ps

module fmvp_pack (
  input  fmvp_pkg::item_t                 item,
  input  fmvp_pkg::held_t                 held,
  input  logic [fmvp_pkg::OpEnW-1:0]      operator_enable,
  output fmvp_pkg::held_t                 held_next,
  output fmvp_pkg::packed_res_t           res
);

  logic [fmvp_pkg::PosW-1:0]  pos;
  logic [fmvp_pkg::ByteW-1:0] b;
  logic [2:0]                 op;
  logic [fmvp_pkg::PosW-1:0]  op_first;
  logic [fmvp_pkg::OffW-1:0]  op_base;
  logic [fmvp_pkg::PosW-1:0]  r_wide;
  logic [4:0]                 r;
  logic                       slot_ok;
  logic                       name_end;
  logic [fmvp_pkg::PosW-1:0]  pos_rel;

  assign pos     = item.unpacked_position;
  assign b       = item.byte_value;
  assign slot_ok = 32'(item.voice_slot) < fmvp_pkg::VoiceSlots;

  always_comb begin
    op = 3'(32'(pos >= 8'd21) + 32'(pos >= 8'd42) + 32'(pos >= 8'd63) +
            32'(pos >= 8'd84) + 32'(pos >= 8'd105));
    case (op)
      3'd0:    begin op_first = 8'd0;   op_base = 7'd0;  end
      3'd1:    begin op_first = 8'd21;  op_base = 7'd17; end
      3'd2:    begin op_first = 8'd42;  op_base = 7'd34; end
      3'd3:    begin op_first = 8'd63;  op_base = 7'd51; end
      3'd4:    begin op_first = 8'd84;  op_base = 7'd68; end
      default: begin op_first = 8'd105; op_base = 7'd85; end
    endcase
    r_wide  = pos - op_first;
    r       = r_wide[4:0];
    pos_rel = pos - fmvp_pkg::PosNameFirst;
  end

  always_comb begin
    held_next  = held;
    res.emit   = 1'b0;
    res.offset = '0;
    res.value  = b;
    name_end   = held.name_ended;
    if (slot_ok && pos <= fmvp_pkg::PosLast) begin
      res.emit = 1'b1;
      if (pos < fmvp_pkg::PosOpEnd) begin
        case (r)
          5'd11: begin
            held_next.left_curve = b[1:0];
            res.emit = 1'b0;
          end
          5'd12: begin
            res.offset = op_base + 7'd11;
            res.value  = {4'd0, b[1:0], held.left_curve};
          end
          5'd13: begin
            held_next.rate_scaling = b[2:0];
            res.emit = 1'b0;
          end
          5'd14: begin
            held_next.amp_mod_sens = b[1:0];
            res.emit = 1'b0;
          end
          5'd15: begin
            res.offset = op_base + 7'd13;
            res.value  = {3'd0, b[2:0], held.amp_mod_sens};
          end
          5'd16: begin
            res.offset = op_base + 7'd14;
            res.value  = operator_enable[op] ? b : 8'd0;
          end
          5'd17: begin
            held_next.osc_mode = b[0];
            res.emit = 1'b0;
          end
          5'd18: begin
            res.offset = op_base + 7'd15;
            res.value  = {2'd0, b[4:0], held.osc_mode};
          end
          5'd19: begin
            res.offset = op_base + 7'd16;
          end
          5'd20: begin
            res.offset = op_base + 7'd12;
            res.value  = {1'b0, b[3:0], held.rate_scaling};
          end
          default: begin
            res.offset = op_base + 7'(r);
          end
        endcase
      end else if (pos <= fmvp_pkg::PosGlobalEnd) begin
        res.offset = 7'(pos - 8'd24);
      end else if (pos == fmvp_pkg::PosFeedback) begin
        held_next.feedback = b[2:0];
        res.emit = 1'b0;
      end else if (pos == fmvp_pkg::PosOscSync) begin
        res.offset = 7'd111;
        res.value  = {4'd0, b[0], held.feedback};
      end else if (pos <= fmvp_pkg::PosGlobal2) begin
        res.offset = 7'(pos - 8'd25);
      end else if (pos == fmvp_pkg::PosLfoSync) begin
        held_next.lfo_sync = b[0];
        res.emit = 1'b0;
      end else if (pos == fmvp_pkg::PosLfoWave) begin
        held_next.lfo_wave = b[2:0];
        res.emit = 1'b0;
      end else if (pos == fmvp_pkg::PosLfoPacked) begin
        res.offset = 7'd116;
        res.value  = {1'b0, b[2:0], held.lfo_wave, held.lfo_sync};
      end else if (pos == fmvp_pkg::PosTranspose) begin
        res.offset = 7'd117;
      end else begin
        if (pos == fmvp_pkg::PosNameFirst) begin
          name_end = 1'b0;
        end
        if (b == 8'd0) begin
          name_end = 1'b1;
        end
        held_next.name_ended = name_end;
        res.offset = 7'd118 + pos_rel[6:0];
        if (name_end || b < 8'd32 || b > 8'd127) begin
          res.value = fmvp_pkg::CharSpace;
        end
      end
    end
  end

endmodule

// ===== rtl/fm_voice_parameter_packer_top.sv =====
// Top level of the FM voice parameter packer.
// Holds the input stage, the held fields and the result register.
// Depends on fmvp_pkg and fmvp_pack.
`timescale 1ns / 1ps

// The block takes one unpacked voice byte per transaction on the s_axis
// channel and writes packed cartridge bytes on the m_axis channel.
// Bytes of one voice must arrive in ascending position order. Held
// positions and ignored items produce no output transaction.
// The cfg channel writes operator_enable; it is always ready and should be
// written only while no items are in flight.
// An item goes to an input register, is packed by combinational logic
// and lands in the result register, which drives m_axis_tvalid.
// Throughput is one item per cycle while the receiver does not stall,
// set by the single input register and the single result register.
// When the receiver stalls, the result register holds its transaction and
// the input register takes one more item; s_axis_tready drops after that.
// Items that give no result still drain during a stall.
// Synchronous reset empties both registers, clears the held fields and
// sets operator_enable to all ones.

module fm_voice_parameter_packer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmvp_pkg::OpEnW-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: voice_slot[4:0], unpacked_position[12:5], byte_value[20:13].
  input  logic [fmvp_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: packed_address[12:0], packed_byte[20:13].
  output logic [fmvp_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic [fmvp_pkg::OpEnW-1:0] operator_enable;
  logic                       in_valid;
  fmvp_pkg::item_t            in_item;
  fmvp_pkg::held_t            held;
  fmvp_pkg::held_t            held_next;
  fmvp_pkg::packed_res_t      res;
  logic                       in_advance;
  logic                       out_load;
  logic                       out_valid;
  logic [fmvp_pkg::AddrW-1:0] out_addr;
  logic [fmvp_pkg::ByteW-1:0] out_byte;
  logic [fmvp_pkg::AddrW-1:0] addr_next;

  fmvp_pack u_pack (
    .item            (in_item),
    .held            (held),
    .operator_enable (operator_enable),
    .held_next       (held_next),
    .res             (res)
  );

  assign cfg_ready     = 1'b1;
  assign in_advance    = in_valid && (!res.emit || !out_valid || m_axis_tready);
  assign out_load      = in_advance && res.emit;
  assign s_axis_tready = !in_valid || in_advance;
  assign addr_next     = {in_item.voice_slot, res.offset} + fmvp_pkg::AddrBase;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_byte, out_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      operator_enable <= '1;
    end else if (cfg_valid) begin
      operator_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.voice_slot        <= s_axis_tdata[4:0];
      in_item.unpacked_position <= s_axis_tdata[12:5];
      in_item.byte_value        <= s_axis_tdata[20:13];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_advance) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr <= addr_next;
      out_byte <= res.value;
    end
  end

endmodule

// ===== tb/fm_voice_parameter_packer_top_test.sv =====
// Self-checking testbench for fm_voice_parameter_packer_top.
// Runs a directed table, then random streams, checking each write against table or predictor.
// Depends on fmvp_pkg and the packer RTL.
`timescale 1ns / 1ps

module fm_voice_parameter_packer_top_test;

  localparam int ItemTarget    = 1400;
  localparam int CycleLimit    = 1_000_000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 4;

  localparam int OpStride          = 21;
  localparam int OpPackedSize      = 17;
  localparam int OpLastDirect      = 10;
  localparam int OpHeldLeftCurve   = 11;
  localparam int OpCurves          = 12;
  localparam int OpHeldRateScale   = 13;
  localparam int OpHeldAmpModSens  = 14;
  localparam int OpAmpModVelocity  = 15;
  localparam int OpOutputLevel     = 16;
  localparam int OpHeldOscMode     = 17;
  localparam int OpFreqCoarse      = 18;
  localparam int OpFreqFine        = 19;

  typedef struct packed {
    logic [fmvp_pkg::AddrW-1:0] addr;
    logic [fmvp_pkg::ByteW-1:0] data;
  } cart_write_t;

  typedef struct packed {
    fmvp_pkg::item_t            it;
    logic                       typed;
    logic                       emit;
    logic [fmvp_pkg::AddrW-1:0] addr;
    logic [fmvp_pkg::ByteW-1:0] data;
  } step_row_t;

  typedef enum {SEQ_VOICE, SEQ_BROKEN, SEQ_NOISE} sequence_kind_t;

  localparam int DirectedCount = 25;
  localparam step_row_t DirectedRows [DirectedCount] = '{
    '{'{5'd0,  8'd0,   8'hff}, 1'b1, 1'b1, 13'd6,    8'hff},
    '{'{5'd31, 8'd0,   8'h00}, 1'b1, 1'b1, 13'd3974, 8'h00},
    '{'{5'd31, 8'd154, 8'h7f}, 1'b1, 1'b1, 13'd4101, 8'h7f},
    '{'{5'd0,  8'd155, 8'h55}, 1'b1, 1'b0, 13'd0,    8'h00},
    '{'{5'd31, 8'd255, 8'haa}, 1'b1, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd145, 8'h41}, 1'b1, 1'b1, 13'd124,  8'h41},
    '{'{5'd0,  8'd146, 8'h1f}, 1'b1, 1'b1, 13'd125,  8'h20},
    '{'{5'd0,  8'd147, 8'h80}, 1'b1, 1'b1, 13'd126,  8'h20},
    '{'{5'd0,  8'd148, 8'h00}, 1'b1, 1'b1, 13'd127,  8'h20},
    '{'{5'd0,  8'd149, 8'h42}, 1'b1, 1'b1, 13'd128,  8'h20},
    '{'{5'd0,  8'd145, 8'h43}, 1'b1, 1'b1, 13'd124,  8'h43},
    '{'{5'd0,  8'd11,  8'hff}, 1'b1, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd12,  8'h03}, 1'b1, 1'b1, 13'd17,   8'h0f},
    '{'{5'd0,  8'd13,  8'ha5}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd14,  8'h5a}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd15,  8'hff}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd16,  8'hc3}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd17,  8'hff}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd18,  8'hff}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd20,  8'hff}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd135, 8'h07}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd136, 8'hff}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd141, 8'h01}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd142, 8'h07}, 1'b0, 1'b0, 13'd0,    8'h00},
    '{'{5'd0,  8'd143, 8'hff}, 1'b0, 1'b0, 13'd0,    8'h00}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fmvp_pkg::OpEnW-1:0]    cfg_data = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fmvp_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fmvp_pkg::OutDataW-1:0] m_axis_tdata;

  fmvp_pkg::held_t             held;
  logic [fmvp_pkg::OpEnW-1:0]  op_enable;
  cart_write_t                 cart_writes_due [$];

  int  error_count = 0;
  int  writes_checked = 0;
  int  voice_bytes_taken = 0;
  int  ignored_taken = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  rx_stall_left = 0;
  int  hold_off_left = 0;
  bit  hold_off_request = 1'b0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;

  fm_voice_parameter_packer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Computes the cartridge write caused by one unpacked byte and updates the held fields.
  function automatic bit pack_voice_byte(input fmvp_pkg::item_t it, output cart_write_t wr);
    int         pos;
    int         op;
    int         r;
    int         base;
    int         off;
    int         addr_sum;
    logic [7:0] bv;
    logic [7:0] val;
    bit         emit;
    pos  = int'(it.unpacked_position);
    bv   = it.byte_value;
    emit = 1'b1;
    off  = 0;
    val  = '0;
    wr   = '0;
    if (int'(it.voice_slot) >= fmvp_pkg::VoiceSlots || pos > int'(fmvp_pkg::PosLast)) begin
      return 1'b0;
    end
    if (pos < int'(fmvp_pkg::PosOpEnd)) begin
      op   = pos / OpStride;
      r    = pos % OpStride;
      base = op * OpPackedSize;
      if (r <= OpLastDirect) begin
        off = base + r;
        val = bv;
      end else begin
        case (r)
          OpHeldLeftCurve: begin
            held.left_curve = bv[1:0];
            emit = 1'b0;
          end
          OpCurves: begin
            off = base + 11;
            val = {4'b0, bv[1:0], held.left_curve};
          end
          OpHeldRateScale: begin
            held.rate_scaling = bv[2:0];
            emit = 1'b0;
          end
          OpHeldAmpModSens: begin
            held.amp_mod_sens = bv[1:0];
            emit = 1'b0;
          end
          OpAmpModVelocity: begin
            off = base + 13;
            val = {3'b0, bv[2:0], held.amp_mod_sens};
          end
          OpOutputLevel: begin
            off = base + 14;
            val = op_enable[op] ? bv : 8'h00;
          end
          OpHeldOscMode: begin
            held.osc_mode = bv[0];
            emit = 1'b0;
          end
          OpFreqCoarse: begin
            off = base + 15;
            val = {2'b0, bv[4:0], held.osc_mode};
          end
          OpFreqFine: begin
            off = base + 16;
            val = bv;
          end
          default: begin
            off = base + 12;
            val = {1'b0, bv[3:0], held.rate_scaling};
          end
        endcase
      end
    end else if (pos <= int'(fmvp_pkg::PosGlobalEnd)) begin
      off = 102 + pos - int'(fmvp_pkg::PosOpEnd);
      val = bv;
    end else if (pos == int'(fmvp_pkg::PosFeedback)) begin
      held.feedback = bv[2:0];
      emit = 1'b0;
    end else if (pos == int'(fmvp_pkg::PosOscSync)) begin
      off = 111;
      val = {4'b0, bv[0], held.feedback};
    end else if (pos <= int'(fmvp_pkg::PosGlobal2)) begin
      off = 112 + pos - int'(fmvp_pkg::PosOscSync) - 1;
      val = bv;
    end else if (pos == int'(fmvp_pkg::PosLfoSync)) begin
      held.lfo_sync = bv[0];
      emit = 1'b0;
    end else if (pos == int'(fmvp_pkg::PosLfoWave)) begin
      held.lfo_wave = bv[2:0];
      emit = 1'b0;
    end else if (pos == int'(fmvp_pkg::PosLfoPacked)) begin
      off = 116;
      val = {1'b0, bv[2:0], held.lfo_wave, held.lfo_sync};
    end else if (pos == int'(fmvp_pkg::PosTranspose)) begin
      off = 117;
      val = bv;
    end else begin
      if (pos == int'(fmvp_pkg::PosNameFirst)) held.name_ended = 1'b0;
      if (bv == 8'h00) held.name_ended = 1'b1;
      off = 118 + pos - int'(fmvp_pkg::PosNameFirst);
      val = (held.name_ended || bv < 8'd32 || bv > 8'd127) ? fmvp_pkg::CharSpace : bv;
    end
    addr_sum = int'(fmvp_pkg::AddrBase) + int'(it.voice_slot) * 128 + off;
    wr.addr  = addr_sum[fmvp_pkg::AddrW-1:0];
    wr.data  = val;
    return emit;
  endfunction

  function automatic logic [7:0] voice_byte_value(input int pos);
    int pick;
    if (pos < int'(fmvp_pkg::PosNameFirst)) return 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 14);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'($urandom_range(1, 31));
    if (pick == 2) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 127));
  endfunction

  task automatic offer_voice_byte(input fmvp_pkg::item_t it, input logic typed,
                                  input logic typed_emit, input cart_write_t typed_wr);
    int          gap;
    cart_write_t wr;
    bit          emit;
    gap = tx_gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.byte_value, it.unpacked_position, it.voice_slot};
    do @(posedge clk); while (!s_axis_tready);
    emit = pack_voice_byte(it, wr);
    if (typed) begin
      emit = typed_emit;
      wr   = typed_wr;
    end
    if (emit) cart_writes_due.push_back(wr);
    if (it.unpacked_position <= fmvp_pkg::PosLast) voice_bytes_taken++;
    else ignored_taken++;
  endtask

  task automatic offer_random(input fmvp_pkg::item_t it);
    offer_voice_byte(it, 1'b0, 1'b0, '0);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (cart_writes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_operator_enable(input logic [fmvp_pkg::OpEnW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    op_enable = value;
    settings_used++;
  endtask

  task automatic send_voice(input logic [fmvp_pkg::SlotW-1:0] slot);
    fmvp_pkg::item_t it;
    for (int pos = 0; pos <= int'(fmvp_pkg::PosLast); pos++) begin
      if ($urandom_range(0, 49) == 0) begin
        it.voice_slot        = 5'($urandom_range(0, 31));
        it.unpacked_position = 8'($urandom_range(int'(fmvp_pkg::PosLast) + 1, 255));
        it.byte_value        = 8'($urandom_range(0, 255));
        offer_random(it);
      end
      it.voice_slot        = slot;
      it.unpacked_position = 8'(pos);
      it.byte_value        = voice_byte_value(pos);
      offer_random(it);
    end
  endtask

  task automatic send_broken_voice();
    fmvp_pkg::item_t it;
    int              pos;
    int              pick;
    it.voice_slot = 5'($urandom_range(0, 31));
    pos = $urandom_range(0, int'(fmvp_pkg::PosLast));
    repeat (40) begin
      it.unpacked_position = 8'(pos);
      it.byte_value        = voice_byte_value(pos);
      offer_random(it);
      pick = $urandom_range(0, 9);
      if (pick < 6) pos += $urandom_range(1, 3);
      else if (pick < 8) pos = $urandom_range(0, int'(fmvp_pkg::PosLast));
      if (pos > int'(fmvp_pkg::PosLast)) pos = $urandom_range(0, int'(fmvp_pkg::PosLast));
    end
  endtask

  task automatic send_noise();
    fmvp_pkg::item_t it;
    repeat (20) begin
      it.voice_slot        = 5'($urandom_range(0, 31));
      it.unpacked_position = 8'($urandom_range(0, 255));
      it.byte_value        = 8'($urandom_range(0, 255));
      offer_random(it);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("fm_voice_parameter_packer_top_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    cart_write_t got;
    cart_write_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[fmvp_pkg::AddrW-1:0];
        got.data = m_axis_tdata[fmvp_pkg::AddrW +: fmvp_pkg::ByteW];
        if (cart_writes_due.size() == 0) begin
          report_mismatch($sformatf("write of 0x%0h to 0x%0h with nothing expected",
                                    got.data, got.addr));
        end else begin
          want = cart_writes_due.pop_front();
          if (got.addr != want.addr) begin
            report_mismatch($sformatf("address 0x%0h, want 0x%0h", got.addr, want.addr));
          end
          if (got.data != want.data) begin
            report_mismatch($sformatf("byte 0x%0h at 0x%0h, want 0x%0h",
                                      got.data, want.addr, want.data));
          end
          writes_checked++;
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_off_left = HoldOffCycles;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_stalls_on) rx_stall_left = idle_length();
      end
    end
  end

  initial begin
    int                         phase;
    logic [fmvp_pkg::OpEnW-1:0] enable_value;
    sequence_kind_t             kind;
    cart_write_t                left;
    held = '0;
    op_enable = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      offer_voice_byte(DirectedRows[i].it, DirectedRows[i].typed, DirectedRows[i].emit,
                       '{DirectedRows[i].addr, DirectedRows[i].data});
    end

    phase = 0;
    while (voice_bytes_taken < ItemTarget) begin
      settle_block();
      case (phase)
        0: enable_value = 6'h00;
        1: enable_value = 6'h3f;
        2: enable_value = 6'h15;
        3: enable_value = 6'h2a;
        default: enable_value = 6'($urandom_range(0, 63));
      endcase
      write_operator_enable(enable_value);
      tx_gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      if (phase == 2) hold_off_request = 1'b1;
      case ($urandom_range(0, 9))
        7, 8: kind = SEQ_BROKEN;
        9: kind = SEQ_NOISE;
        default: kind = SEQ_VOICE;
      endcase
      if (phase < 3) kind = SEQ_VOICE;
      case (kind)
        SEQ_BROKEN: send_broken_voice();
        SEQ_NOISE: send_noise();
        default: send_voice(5'($urandom_range(0, 31)));
      endcase
      phase++;
    end

    settle_block();
    repeat (8) @(posedge clk);
    while (cart_writes_due.size() != 0) begin
      left = cart_writes_due.pop_front();
      report_mismatch($sformatf("write of 0x%0h to 0x%0h never arrived", left.data, left.addr));
    end
    $display("covered %0d voice bytes and %0d out-of-range positions; %0d packed writes checked",
             voice_bytes_taken, ignored_taken, writes_checked);
    $display("operator enable set %0d times, all-off and all-on among them", settings_used);
    if (error_count == 0) begin
      $display("fm_voice_parameter_packer_top_test: done, clean");
    end else begin
      $display("fm_voice_parameter_packer_top_test: done, errors");
    end
    $finish;
  end

endmodule
